### design/alist_pkg.sv
// shared types, codes and constants for the array list block
`default_nettype none

package alist_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 3;
  localparam int POS_W        = 4;
  localparam int STATUS_W     = 3;
  localparam int CNT_OUT_W    = 4;
  localparam int IN_W         = 40;  // req_type, position, value, padded to bytes
  localparam int OUT_W        = 48;  // status .. list_full, padded to bytes

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SEARCH  = 3'd2,
    REQ_READOUT = 3'd3,
    REQ_STATUS  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_BAD_POS   = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RO_RD,
    ST_RO_OUT,
    ST_RESP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PREV,
    RD_NEXT,
    RD_IDX
  } rd_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_RDATA,
    WR_VALUE
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // controller to datapath
  typedef struct packed {
    logic    load_req;
    idx_op_e idx_op;
    rd_op_e  rd_op;
    wr_op_e  wr_op;
    cnt_op_e cnt_op;
    logic    out_load;
    status_e out_status;
    logic    out_pos;    // report idx+1 as position
    logic    out_entry;  // report read data as entry value
    logic    out_last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             cnt_zero;
    logic             cnt_full;
    logic             ins_bad;
    logic             del_bad;
    logic             ins_done;
    logic             idx_last;
    logic             match;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/alist_ctrl.sv
// controller state machine for the array list block
`default_nettype none

module alist_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire alist_pkg::dp_stat_t  stat_i,
  output alist_pkg::ctrl_cmd_t      cmd_o
);

  alist_pkg::state_e  state_q, state_d;
  alist_pkg::status_e resp_q, resp_d;
  logic               hit_q, hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alist_pkg::ST_IDLE;
      resp_q  <= alist_pkg::STATUS_OK;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
      hit_q   <= hit_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    hit_d   = hit_q;
    unique case (state_q)
      alist_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = alist_pkg::ST_DECODE;
        end
      end
      alist_pkg::ST_DECODE: begin
        hit_d  = 1'b0;
        resp_d = alist_pkg::STATUS_OK;
        unique case (stat_i.req_type)
          alist_pkg::REQ_INSERT: begin
            if (stat_i.cnt_full) begin
              resp_d  = alist_pkg::STATUS_FULL;
              state_d = alist_pkg::ST_RESP;
            end else if (stat_i.ins_bad) begin
              resp_d  = alist_pkg::STATUS_BAD_POS;
              state_d = alist_pkg::ST_RESP;
            end else begin
              state_d = alist_pkg::ST_INS_RD;
            end
          end
          alist_pkg::REQ_DELETE: begin
            if (stat_i.cnt_zero) begin
              resp_d  = alist_pkg::STATUS_EMPTY;
              state_d = alist_pkg::ST_RESP;
            end else if (stat_i.del_bad) begin
              resp_d  = alist_pkg::STATUS_BAD_POS;
              state_d = alist_pkg::ST_RESP;
            end else begin
              state_d = alist_pkg::ST_DEL_RD;
            end
          end
          alist_pkg::REQ_SEARCH: begin
            if (stat_i.cnt_zero) begin
              resp_d  = alist_pkg::STATUS_EMPTY;
              state_d = alist_pkg::ST_RESP;
            end else begin
              state_d = alist_pkg::ST_SRCH_RD;
            end
          end
          alist_pkg::REQ_READOUT: begin
            if (stat_i.cnt_zero) begin
              resp_d  = alist_pkg::STATUS_EMPTY;
              state_d = alist_pkg::ST_RESP;
            end else begin
              state_d = alist_pkg::ST_RO_RD;
            end
          end
          alist_pkg::REQ_STATUS: begin
            state_d = alist_pkg::ST_RESP;
          end
          default: begin
            state_d = alist_pkg::ST_IDLE;  // unknown request, no result
          end
        endcase
      end
      alist_pkg::ST_INS_RD: begin
        state_d = stat_i.ins_done ? alist_pkg::ST_RESP : alist_pkg::ST_INS_WR;
      end
      alist_pkg::ST_INS_WR: begin
        state_d = alist_pkg::ST_INS_RD;
      end
      alist_pkg::ST_DEL_RD: begin
        state_d = stat_i.idx_last ? alist_pkg::ST_RESP : alist_pkg::ST_DEL_WR;
      end
      alist_pkg::ST_DEL_WR: begin
        state_d = alist_pkg::ST_DEL_RD;
      end
      alist_pkg::ST_SRCH_RD: begin
        state_d = alist_pkg::ST_SRCH_CMP;
      end
      alist_pkg::ST_SRCH_CMP: begin
        if (stat_i.match) begin
          hit_d   = 1'b1;
          state_d = alist_pkg::ST_RESP;
        end else if (stat_i.idx_last) begin
          resp_d  = alist_pkg::STATUS_NOT_FOUND;
          state_d = alist_pkg::ST_RESP;
        end else begin
          state_d = alist_pkg::ST_SRCH_RD;
        end
      end
      alist_pkg::ST_RO_RD: begin
        state_d = alist_pkg::ST_RO_OUT;
      end
      alist_pkg::ST_RO_OUT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.idx_last ? alist_pkg::ST_IDLE : alist_pkg::ST_RO_RD;
        end
      end
      alist_pkg::ST_RESP: begin
        if (stat_i.out_free) begin
          state_d = alist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = alist_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.idx_op      = alist_pkg::IDX_HOLD;
    cmd_o.rd_op       = alist_pkg::RD_NONE;
    cmd_o.wr_op       = alist_pkg::WR_NONE;
    cmd_o.cnt_op      = alist_pkg::CNT_HOLD;
    cmd_o.out_status  = alist_pkg::STATUS_OK;
    unique case (state_q) inside
      alist_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      alist_pkg::ST_DECODE: begin
        unique case (stat_i.req_type) inside
          alist_pkg::REQ_INSERT:  cmd_o.idx_op = alist_pkg::IDX_COUNT;
          alist_pkg::REQ_DELETE:  cmd_o.idx_op = alist_pkg::IDX_POS;
          alist_pkg::REQ_SEARCH,
          alist_pkg::REQ_READOUT: cmd_o.idx_op = alist_pkg::IDX_ZERO;
          default:                cmd_o.idx_op = alist_pkg::IDX_HOLD;
        endcase
      end
      alist_pkg::ST_INS_RD: begin
        if (stat_i.ins_done) begin
          cmd_o.wr_op  = alist_pkg::WR_VALUE;
          cmd_o.cnt_op = alist_pkg::CNT_INC;
        end else begin
          cmd_o.rd_op = alist_pkg::RD_PREV;
        end
      end
      alist_pkg::ST_INS_WR: begin
        cmd_o.wr_op  = alist_pkg::WR_RDATA;
        cmd_o.idx_op = alist_pkg::IDX_DEC;
      end
      alist_pkg::ST_DEL_RD: begin
        if (stat_i.idx_last) begin
          cmd_o.cnt_op = alist_pkg::CNT_DEC;
        end else begin
          cmd_o.rd_op = alist_pkg::RD_NEXT;
        end
      end
      alist_pkg::ST_DEL_WR: begin
        cmd_o.wr_op  = alist_pkg::WR_RDATA;
        cmd_o.idx_op = alist_pkg::IDX_INC;
      end
      alist_pkg::ST_SRCH_RD,
      alist_pkg::ST_RO_RD: begin
        cmd_o.rd_op = alist_pkg::RD_IDX;
      end
      alist_pkg::ST_SRCH_CMP: begin
        if (!stat_i.match && !stat_i.idx_last) begin
          cmd_o.idx_op = alist_pkg::IDX_INC;
        end
      end
      alist_pkg::ST_RO_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_pos   = 1'b1;
          cmd_o.out_entry = 1'b1;
          cmd_o.out_last  = stat_i.idx_last;
          if (!stat_i.idx_last) begin
            cmd_o.idx_op = alist_pkg::IDX_INC;
          end
        end
      end
      alist_pkg::ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          cmd_o.out_pos    = hit_q;
          cmd_o.out_last   = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/alist_dp.sv
// datapath of the array list block: entry memory, count, walk index, result register
`default_nettype none

module alist_dp #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [alist_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [alist_pkg::POS_W-1:0]    position_i,
  input  wire logic [alist_pkg::DATA_W-1:0]   value_i,
  input  wire alist_pkg::ctrl_cmd_t           cmd_i,
  output alist_pkg::dp_stat_t                 stat_o,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic [alist_pkg::OUT_W-1:0]         out_data_o,
  output logic                                out_last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = ((CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W) + 1;
  localparam int PAD_W = alist_pkg::OUT_W - alist_pkg::STATUS_W - alist_pkg::POS_W
                         - alist_pkg::DATA_W - alist_pkg::CNT_OUT_W - 2;

  logic [alist_pkg::DATA_W-1:0] mem [CAPACITY];

  logic [alist_pkg::REQ_W-1:0]  req_type_q;
  logic [alist_pkg::POS_W-1:0]  pos_q;
  logic [alist_pkg::DATA_W-1:0] value_q;
  logic [alist_pkg::DATA_W-1:0] rdata_q;
  logic [CW-1:0]                count_q, count_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic [AW-1:0]                rd_addr;
  logic [alist_pkg::DATA_W-1:0] wr_data;
  logic [PW-1:0]                idx_ext, cnt_ext, pos_ext;
  logic                         cnt_full;
  logic                         out_valid_q;
  logic [alist_pkg::OUT_W-1:0]  out_data_q, out_data_d;
  logic                         out_last_q;
  logic                         out_free;

  assign idx_ext  = PW'(idx_q);
  assign cnt_ext  = PW'(count_q);
  assign pos_ext  = PW'(pos_q);
  assign cnt_full = (cnt_ext >= PW'(CAPACITY));
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      pos_q      <= position_i;
      value_q    <= value_i;
    end
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      alist_pkg::IDX_COUNT: idx_d = AW'(count_q);
      alist_pkg::IDX_POS:   idx_d = AW'(pos_ext - PW'(1));
      alist_pkg::IDX_ZERO:  idx_d = '0;
      alist_pkg::IDX_INC:   idx_d = idx_q + AW'(1);
      alist_pkg::IDX_DEC:   idx_d = idx_q - AW'(1);
      default:              idx_d = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      alist_pkg::CNT_INC: count_d = count_q + CW'(1);
      alist_pkg::CNT_DEC: count_d = count_q - CW'(1);
      default:            count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  // one read and one write port, registered read data
  always_comb begin
    unique case (cmd_i.rd_op)
      alist_pkg::RD_PREV: rd_addr = idx_q - AW'(1);
      alist_pkg::RD_NEXT: rd_addr = idx_q + AW'(1);
      default:            rd_addr = idx_q;
    endcase
  end

  assign wr_data = (cmd_i.wr_op == alist_pkg::WR_VALUE) ? value_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_op != alist_pkg::RD_NONE) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.wr_op != alist_pkg::WR_NONE) begin
      mem[idx_q] <= wr_data;
    end
  end

  // result register, fields listed from the high bit down
  always_comb begin
    out_data_d = {
      PAD_W'(0),
      cnt_full,
      (count_q == '0),
      alist_pkg::CNT_OUT_W'(count_q),
      cmd_i.out_entry ? rdata_q : alist_pkg::DATA_W'(0),
      cmd_i.out_pos ? alist_pkg::POS_W'(idx_ext + PW'(1)) : alist_pkg::POS_W'(0),
      cmd_i.out_status
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_data_d;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    stat_o          = '0;
    stat_o.req_type = req_type_q;
    stat_o.cnt_zero = (count_q == '0);
    stat_o.cnt_full = cnt_full;
    stat_o.ins_bad  = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
    stat_o.del_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
    stat_o.ins_done = (idx_ext == pos_ext - PW'(1));
    stat_o.idx_last = (idx_ext + PW'(1) == cnt_ext);
    stat_o.match    = (rdata_q == value_q);
    stat_o.out_free = out_free;
  end

endmodule

`default_nettype wire

### design/array_list_insert_delete_search.sv
// top level of the array list block: ordered list with insert, delete, search and read-out
//
//  channel  | dir | tdata fields (low bit up)                        | tlast
//  ---------+-----+--------------------------------------------------+---------------
//  s_axis   | in  | req_type[3] position[4] value[32] pad[1]         | -
//  m_axis   | out | status[3] found_position[4] entry_value[32]      | final result
//           |     | entry_count[4] list_empty[1] list_full[1] pad[3] | of the request
//
//  one request is worked at a time; s_axis_tready is high only while the controller is idle
//  status request: decode, then result; insert and delete move each entry by a read and
//  a write, insert from the tail down to the position, then writes the value; delete from
//  the position to the tail; search and read-out step through the single memory read port
//  a stalled m_axis holds the result register and blocks the next result, not the next accept
//  reset clears the count and the controller; entry memory needs no clearing pass
`default_nettype none

module array_list_insert_delete_search #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request transaction
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [alist_pkg::IN_W-1:0]   s_axis_tdata,   // req_type, position, value
  // result transaction
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [alist_pkg::OUT_W-1:0]       m_axis_tdata,   // status, found_position,
                                                            // entry_value, entry_count,
                                                            // list_empty, list_full
  output logic                              m_axis_tlast
);

  alist_pkg::ctrl_cmd_t cmd;
  alist_pkg::dp_stat_t  stat;

  // request fields, lowest first
  logic [alist_pkg::REQ_W-1:0]  req_type;
  logic [alist_pkg::POS_W-1:0]  position;
  logic [alist_pkg::DATA_W-1:0] value;

  assign req_type = s_axis_tdata[alist_pkg::REQ_W-1:0];
  assign position = s_axis_tdata[alist_pkg::REQ_W +: alist_pkg::POS_W];
  assign value    = s_axis_tdata[alist_pkg::REQ_W + alist_pkg::POS_W +: alist_pkg::DATA_W];

  // sequencer: decodes the request, walks the list, schedules results
  alist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // entry store, count, walk index and the result register
  alist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (req_type),
    .position_i  (position),
    .value_i     (value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### design/alist_checker.sv
// port-level checks for the array list block, bound to the top level
`default_nettype none

module alist_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [alist_pkg::OUT_W-1:0]  m_axis_tdata,
  input wire logic                         m_axis_tlast
);

  logic [alist_pkg::STATUS_W-1:0] res_status;
  logic [alist_pkg::POS_W-1:0]    res_pos;
  logic [alist_pkg::DATA_W-1:0]   res_entry;
  logic                           res_empty;
  logic                           res_full;

  assign res_status = m_axis_tdata[alist_pkg::STATUS_W-1:0];
  assign res_pos    = m_axis_tdata[alist_pkg::STATUS_W +: alist_pkg::POS_W];
  assign res_entry  = m_axis_tdata[alist_pkg::STATUS_W + alist_pkg::POS_W +: alist_pkg::DATA_W];
  assign res_empty  = m_axis_tdata[alist_pkg::STATUS_W + alist_pkg::POS_W + alist_pkg::DATA_W
                                   + alist_pkg::CNT_OUT_W];
  assign res_full   = m_axis_tdata[alist_pkg::STATUS_W + alist_pkg::POS_W + alist_pkg::DATA_W
                                   + alist_pkg::CNT_OUT_W + 1];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a request is worked alone: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // the list cannot be empty and full at once
  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_empty && res_full))
    else $error("list reported empty and full");

  // an error result is single, with no position and no entry
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_status != alist_pkg::STATUS_OK) |->
      m_axis_tlast && (res_pos == '0) && (res_entry == '0))
    else $error("error result malformed");

endmodule

bind array_list_insert_delete_search alist_checker u_alist_checker (.*);

`default_nettype wire

### sim/array_list_insert_delete_search_test.sv
// self-checking testbench for the array list block: streamed requests against a local list model
module array_list_insert_delete_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import alist_pkg::*;

  localparam int HALF_PERIOD = 4;      // 8 ns clock
  localparam int RESET_CYCLES = 9;
  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT = 2000;    // cycles without any transaction before giving up
  localparam int TAIL_CYCLES = 40;     // longer than the slowest request (a search that misses on a full list)
  localparam int REPORT_MAX = 10;

  // one request as the sender sees it; hold_for_drain makes the sender wait until
  // every outstanding result has come back before presenting it
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic              hold_for_drain;
  } request_t;

  // one result beat, field by field
  typedef struct {
    status_e               status;
    logic [POS_W-1:0]      found_pos;
    logic [DATA_W-1:0]     entry;
    logic [CNT_OUT_W-1:0]  cnt;
    logic                  empty;
    logic                  full;
    logic                  last;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  array_list_insert_delete_search #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // req_type, position, value
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // status, found_position, entry_value, entry_count,
                                    // list_empty, list_full
    .m_axis_tlast (m_axis_tlast)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // local copy of the list, advanced once per accepted request
  logic [DATA_W-1:0] list_mem [LIST_CAP];
  int                list_count = 0;

  request_t     pending_requests [$];
  list_result_t expected_results [$];
  request_t     cur_req;

  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int ready_phase = 0;
  int idle_cycles = 0;

  // append one expected beat; count and flags reflect the list after the request
  function automatic void queue_result(status_e st, int pos, logic [DATA_W-1:0] val, bit fin);
    list_result_t r;
    r.status    = st;
    r.found_pos = pos[POS_W-1:0];
    r.entry     = val;
    r.cnt       = list_count[CNT_OUT_W-1:0];
    r.empty     = (list_count == 0);
    r.full      = (list_count >= LIST_CAP);
    r.last      = fin;
    expected_results.push_back(r);
  endfunction

  // work out the results of one accepted request and update the local list
  function automatic void predict_request(request_t rq);
    int  i;
    bit  hit;
    hit = 1'b0;
    case (rq.req)
      REQ_INSERT: begin
        if (list_count >= LIST_CAP) begin
          queue_result(STATUS_FULL, 0, '0, 1'b1);
        end else if (rq.pos < 1 || int'(rq.pos) > list_count + 1) begin
          queue_result(STATUS_BAD_POS, 0, '0, 1'b1);
        end else begin
          // open a hole at the position by moving later entries up
          for (i = list_count; i >= int'(rq.pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[rq.pos-1] = rq.value;
          list_count++;
          queue_result(STATUS_OK, 0, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (list_count == 0) begin
          queue_result(STATUS_EMPTY, 0, '0, 1'b1);
        end else if (rq.pos < 1 || int'(rq.pos) > list_count) begin
          queue_result(STATUS_BAD_POS, 0, '0, 1'b1);
        end else begin
          for (i = rq.pos - 1; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
          queue_result(STATUS_OK, 0, '0, 1'b1);
        end
      end
      REQ_SEARCH: begin
        if (list_count == 0) begin
          queue_result(STATUS_EMPTY, 0, '0, 1'b1);
        end else begin
          // first matching position wins
          for (i = 0; i < list_count && !hit; i++) begin
            if (list_mem[i] == rq.value) begin
              queue_result(STATUS_OK, i + 1, '0, 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) queue_result(STATUS_NOT_FOUND, 0, '0, 1'b1);
        end
      end
      REQ_READOUT: begin
        if (list_count == 0) begin
          queue_result(STATUS_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < list_count; i++)
            queue_result(STATUS_OK, i + 1, list_mem[i], i + 1 == list_count);
        end
      end
      REQ_STATUS: queue_result(STATUS_OK, 0, '0, 1'b1);
      default: ;  // unknown request types are dropped without a result
    endcase
  endfunction

  task automatic add_req(logic [REQ_W-1:0] req, int pos, logic [DATA_W-1:0] val,
                         bit drain = 1'b0);
    request_t rq;
    rq.req            = req;
    rq.pos            = pos[POS_W-1:0];
    rq.value          = val;
    rq.hold_for_drain = drain;
    pending_requests.push_back(rq);
  endtask

  // values drawn mostly from a small pool so searches hit and duplicates occur
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] pool [8];
    pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
             32'h1, 32'h5, 32'h5555_5555, 32'haaaa_aaaa};
    if ($urandom_range(3) == 0) return $urandom();
    return pool[3'($urandom_range(7))];
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued requests in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_request(cur_req);
      // the slot is free when nothing is shown or the shown request was just taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].hold_for_drain && expected_results.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = pending_requests.pop_front();
          s_axis_tdata  <= {1'b0, cur_req.value, cur_req.pos, cur_req.req};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; about a quarter of the bursts run back to back with no gap
            burst_left = $urandom_range(20, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction against the oldest expectation and
  // drives a back-pressure pattern that switches among four modes chosen at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status    = status_e'(m_axis_tdata[2:0]);
      got.found_pos = m_axis_tdata[6:3];
      got.entry     = m_axis_tdata[38:7];
      got.cnt       = m_axis_tdata[42:39];
      got.empty     = m_axis_tdata[43];
      got.full      = m_axis_tdata[44];
      got.last      = m_axis_tlast;
      if (expected_results.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("unexpected result: st=%0d pos=%0d val=%h cnt=%0d empty=%b full=%b last=%b",
                   got.status, got.found_pos, got.entry, got.cnt, got.empty, got.full,
                   got.last);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.found_pos !== want.found_pos ||
            got.entry !== want.entry || got.cnt !== want.cnt ||
            got.empty !== want.empty || got.full !== want.full || got.last !== want.last) begin
          if (fail_count < REPORT_MAX) begin
            $display("mismatch exp: st=%0d pos=%0d val=%h cnt=%0d empty=%b full=%b last=%b",
                     want.status, want.found_pos, want.entry, want.cnt, want.empty,
                     want.full, want.last);
            $display("         got: st=%0d pos=%0d val=%h cnt=%0d empty=%b full=%b last=%b",
                     got.status, got.found_pos, got.entry, got.cnt, got.empty, got.full,
                     got.last);
          end
          fail_count++;
        end
      end
    end
    if (ready_phase % 97 == 0) ready_mode = $urandom_range(3);
    ready_phase++;
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;                       // no stalls
      1:       m_axis_tready <= 1'($urandom_range(1));      // coin toss
      2:       m_axis_tready <= ($urandom_range(3) == 0);   // mostly stalled
      default: m_axis_tready <= (ready_phase % 8) < 3;      // fixed on/off pattern
    endcase
  end

  // watchdog: give up when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int               plan_count;
    int               planned;
    int               roll;
    int               ins_pct;
    int               pos;
    logic [REQ_W-1:0] req;

    // directed: every request on an empty list, bad positions, extremes, fill to full
    add_req(REQ_STATUS, 0, '0);
    add_req(REQ_DELETE, 1, '0);                   // delete when empty
    add_req(REQ_SEARCH, 0, 32'h0);                // search when empty
    add_req(REQ_READOUT, 0, '0);                  // read-out of an empty list
    add_req(REQ_INSERT, 0, 32'h1234_5678);        // position below range
    add_req(REQ_INSERT, 2, 32'h1234_5678);        // position past count+1
    add_req(REQ_INSERT, 1, 32'h8000_0000);
    add_req(REQ_INSERT, 2, 32'h7fff_ffff);        // append
    add_req(REQ_INSERT, 1, 32'hffff_ffff);        // insert at the head
    add_req(REQ_INSERT, 2, 32'h0);                // insert in the middle
    add_req(REQ_INSERT, 5, 32'h7fff_ffff);        // duplicate value
    add_req(REQ_INSERT, 3, 32'h5555_5555);
    add_req(REQ_INSERT, 1, 32'haaaa_aaaa);
    add_req(REQ_INSERT, 8, 32'h0000_0001);        // list now full
    add_req(REQ_INSERT, 15, 32'h1);               // insert when full
    add_req(REQ_SEARCH, 0, 32'h7fff_ffff);        // first of two matches
    add_req(REQ_SEARCH, 15, 32'h0bad_cafe);       // search miss
    add_req(REQ_READOUT, 0, '0);
    add_req(REQ_STATUS, 15, 32'hffff_ffff);
    add_req(REQ_DELETE, 9, '0);                   // delete past count
    add_req(REQ_DELETE, 0, '0);
    add_req(REQ_DELETE, 8, '0);                   // drop the tail
    add_req(REQ_DELETE, 1, '0);                   // drop the head
    add_req(3'd5, 15, 32'hffff_ffff);             // unknown request types
    add_req(3'd6, 0, '0);
    add_req(3'd7, 9, 32'h8000_0000);

    // random part, planned against a running count so most positions are legal
    plan_count = 6;
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      pos = 0;
      if (roll < 3) begin
        req = REQ_W'($urandom_range(7, 5));
        pos = $urandom_range(15);
      end else begin
        if (roll < 7) req = REQ_STATUS;
        else if (roll < 14) req = REQ_READOUT;
        else if (roll < 34) req = REQ_SEARCH;
        else begin
          // steer the count so it wanders between empty and full
          ins_pct = (plan_count < 3) ? 70 : (plan_count > 6) ? 30 : 50;
          req = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_DELETE;
        end
        if ($urandom_range(9) < 8) begin
          if (req == REQ_INSERT)
            pos = $urandom_range((plan_count < LIST_CAP) ? plan_count + 1 : LIST_CAP, 1);
          else
            pos = $urandom_range((plan_count > 0) ? plan_count : 1, 1);
        end else begin
          pos = $urandom_range(15);
        end
        if (req == REQ_INSERT && plan_count < LIST_CAP && pos >= 1 && pos <= plan_count + 1)
          plan_count++;
        else if (req == REQ_DELETE && plan_count > 0 && pos >= 1 && pos <= plan_count)
          plan_count--;
        planned++;
      end
      // every hundredth request waits for all outstanding results first
      add_req(req, pos, pick_value(), (planned % 100) == 50);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
